// File: hdl/dlsm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the drag latency statistics monitor.
// No dependencies.
package dlsm_pkg;

    localparam int HIST_BINS  = 7;
    localparam int PHASES     = 5;
    localparam int STAT_FIXED = 22;

    localparam logic [2:0] OP_SAMPLE  = 3'd0;
    localparam logic [2:0] OP_MOTION  = 3'd1;
    localparam logic [2:0] OP_MOVED   = 3'd2;
    localparam logic [2:0] OP_SET     = 3'd3;
    localparam logic [2:0] OP_UNBLOCK = 3'd4;
    localparam logic [2:0] OP_END     = 3'd5;

    localparam logic [4:0] IDX_ELAPSED = 5'd0;
    localparam logic [4:0] IDX_STEPS   = 5'd1;
    localparam logic [4:0] IDX_GAP     = 5'd2;
    localparam logic [4:0] IDX_MOTION  = 5'd3;
    localparam logic [4:0] IDX_SKIPPED = 5'd4;
    localparam int         IDX_PHASE   = 5;
    localparam int         IDX_HIST    = 15;

    localparam int PH_WAKE   = 0;
    localparam int PH_APP    = 1;
    localparam int PH_REDRAW = 2;
    localparam int PH_COUNT  = 3;
    localparam int PH_STEP   = 4;

    typedef enum logic [2:0] {
        CMD_SAMPLE,
        CMD_MOTION,
        CMD_MOVED,
        CMD_SET,
        CMD_UNBLOCK,
        CMD_END
    } cmd_t;

    typedef enum logic {
        RD_IDLE,
        RD_BUSY
    } rd_state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [31:0]        time_ms;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               was_blocked;
        logic [15:0]        redraw_count;
        logic [2:0]         reason;
    } evt_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    function automatic logic [2:0] hist_bin(logic [15:0] d);
        logic [2:0] b;
        if (d <= 16'd1)
            b = 3'd0;
        else if (d == 16'd2)
            b = 3'd1;
        else if (d <= 16'd4)
            b = 3'd2;
        else if (d <= 16'd8)
            b = 3'd3;
        else if (d <= 16'd16)
            b = 3'd4;
        else if (d <= 16'd32)
            b = 3'd5;
        else
            b = 3'd6;
        return b;
    endfunction

endpackage

// File: hdl/dlsm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: event words in, statistic words out.
// No dependencies.
interface dlsm_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [31:0]        time_ms;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               was_blocked;
    logic [15:0]        redraw_count;
    logic [2:0]         reason;

    modport source (
        output valid, operation, time_ms, pos_x, pos_y, was_blocked, redraw_count, reason,
        input  ready
    );
    modport sink (
        input  valid, operation, time_ms, pos_x, pos_y, was_blocked, redraw_count, reason,
        output ready
    );
endinterface

interface dlsm_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  stat_index;
    logic [31:0] stat_value;
    logic        last;

    modport source (
        output valid, stat_index, stat_value, last,
        input  ready
    );
    modport sink (
        input  valid, stat_index, stat_value, last,
        output ready
    );
endinterface

// File: hdl/dlsm_front.sv
`timescale 1ns / 1ps
// Front end: accepts event words, decodes the operation, drops unused codes.
// Depends on dlsm_pkg and dlsm_in_if.
module dlsm_front (
    dlsm_in_if.sink            evt,
    input  dlsm_pkg::q_stat_t  q_stat,
    output logic               push,
    output dlsm_pkg::evt_t     push_data
);
    import dlsm_pkg::*;

    logic op_ok;
    cmd_t cmd;

    always_comb
    begin
        op_ok = 1'b1;
        case (evt.operation)
            OP_SAMPLE:  cmd = CMD_SAMPLE;
            OP_MOTION:  cmd = CMD_MOTION;
            OP_MOVED:   cmd = CMD_MOVED;
            OP_SET:     cmd = CMD_SET;
            OP_UNBLOCK: cmd = CMD_UNBLOCK;
            OP_END:     cmd = CMD_END;
            default:
            begin
                cmd   = CMD_SAMPLE;
                op_ok = 1'b0;
            end
        endcase
    end

    assign evt.ready = !q_stat.full;
    assign push      = evt.valid && !q_stat.full && op_ok;

    assign push_data.cmd          = cmd;
    assign push_data.time_ms      = evt.time_ms;
    assign push_data.pos_x        = evt.pos_x;
    assign push_data.pos_y        = evt.pos_y;
    assign push_data.was_blocked  = evt.was_blocked;
    assign push_data.redraw_count = evt.redraw_count;
    assign push_data.reason       = evt.reason;

endmodule

// File: hdl/dlsm_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of decoded events between front and back end.
// Depends on dlsm_pkg.
module dlsm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dlsm_pkg::evt_t    push_data,
    input  logic              pop,
    output dlsm_pkg::evt_t    pop_data,
    output dlsm_pkg::q_stat_t q_stat
);
    import dlsm_pkg::*;

    evt_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data         = mem_reg[rd_ptr_reg];
    assign q_stat.full      = count_reg[1];
    assign q_stat.not_empty = (count_reg != 2'd0);

endmodule

// File: hdl/dlsm_back.sv
`timescale 1ns / 1ps
// Back end: statistics registers, per-event update and the end-of-session readout.
// Depends on dlsm_pkg and dlsm_out_if.
module dlsm_back #(
    parameter int REASON_SLOTS = 5,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dlsm_pkg::q_stat_t q_stat,
    input  dlsm_pkg::evt_t    q_data,
    output logic              pop,
    dlsm_out_if.source        stat
);
    import dlsm_pkg::*;

    localparam int SW = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
    localparam logic [SW-1:0] CNT_MAX = {{(SW - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    localparam logic [SW-1:0] OUT_MAX = {{(SW - 32){1'b0}}, {32{1'b1}}};
    localparam logic [4:0]    LAST_IDX = 5'(STAT_FIXED + REASON_SLOTS - 1);

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    function automatic cnt_t sat_add(cnt_t a, logic [31:0] v);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(v);
        return (s > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX) : COUNT_WIDTH'(s);
    endfunction

    function automatic cnt_t sat_inc(cnt_t a);
        return (a == '1) ? a : a + COUNT_WIDTH'(1);
    endfunction

    function automatic cnt_t max_upd(cnt_t m, logic [31:0] v);
        cnt_t r;
        r = m;
        if (SW'(v) > SW'(m))
            r = (SW'(v) > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX) : COUNT_WIDTH'(v);
        return r;
    endfunction

    logic               session_reg, session_next;
    logic               prev_valid_reg, prev_valid_next;
    logic signed [15:0] prev_x_reg, prev_x_next;
    logic signed [15:0] prev_y_reg, prev_y_next;
    logic [31:0]        start_reg, start_next;
    logic [31:0]        sample_t_reg, sample_t_next;
    logic [31:0]        moved_t_reg, moved_t_next;
    logic               moved_seen_reg, moved_seen_next;
    logic [31:0]        set_t_reg, set_t_next;
    logic               set_seen_reg, set_seen_next;
    cnt_t               steps_reg, steps_next;
    cnt_t               sums_reg [PHASES];
    cnt_t               sums_next [PHASES];
    cnt_t               maxs_reg [PHASES];
    cnt_t               maxs_next [PHASES];
    cnt_t               gap_reg, gap_next;
    cnt_t               hist_reg [HIST_BINS];
    cnt_t               hist_next [HIST_BINS];
    cnt_t               motion_reg, motion_next;
    cnt_t               skipped_reg, skipped_next;
    cnt_t               reasons_reg [REASON_SLOTS];
    cnt_t               reasons_next [REASON_SLOTS];
    logic [31:0]        elapsed_reg, elapsed_next;

    rd_state_t          state_reg, state_next;
    logic [4:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [4:0]         out_index_reg, out_index_next;
    logic [31:0]        out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    logic               load;
    logic               start_rd;
    logic signed [16:0] dx, dy;
    logic [15:0]        ax, ay, step_size;
    logic [2:0]         bin;
    logic [SW-1:0]      sel;

    // step size: Chebyshev distance to the previous sample
    always_comb
    begin
        dx        = 17'(q_data.pos_x) - 17'(prev_x_reg);
        dy        = 17'(q_data.pos_y) - 17'(prev_y_reg);
        ax        = dx[16] ? 16'(-dx) : dx[15:0];
        ay        = dy[16] ? 16'(-dy) : dy[15:0];
        step_size = (ax > ay) ? ax : ay;
        bin       = hist_bin(step_size);
    end

    assign start_rd = pop && (q_data.cmd == CMD_END) && session_reg;

    always_comb
    begin
        session_next    = session_reg;
        prev_valid_next = prev_valid_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        start_next      = start_reg;
        sample_t_next   = sample_t_reg;
        moved_t_next    = moved_t_reg;
        moved_seen_next = moved_seen_reg;
        set_t_next      = set_t_reg;
        set_seen_next   = set_seen_reg;
        steps_next      = steps_reg;
        sums_next       = sums_reg;
        maxs_next       = maxs_reg;
        gap_next        = gap_reg;
        hist_next       = hist_reg;
        motion_next     = motion_reg;
        skipped_next    = skipped_reg;
        reasons_next    = reasons_reg;
        elapsed_next    = elapsed_reg;

        if (pop)
        begin
            case (q_data.cmd)
                CMD_SAMPLE:
                begin
                    if (!session_reg)
                    begin
                        // new session: all statistics but the elapsed time start from zero
                        session_next    = 1'b1;
                        start_next      = q_data.time_ms;
                        moved_t_next    = '0;
                        set_t_next      = '0;
                        gap_next        = '0;
                        motion_next     = '0;
                        skipped_next    = '0;
                        for (int i = 0; i < PHASES; i++)
                        begin
                            sums_next[i] = '0;
                            maxs_next[i] = '0;
                        end
                        for (int i = 0; i < HIST_BINS; i++)
                            hist_next[i] = '0;
                        for (int i = 0; i < REASON_SLOTS; i++)
                            reasons_next[i] = '0;
                    end
                    else if (prev_valid_reg)
                    begin
                        sums_next[PH_STEP] = sat_add(sums_reg[PH_STEP], 32'(step_size));
                        maxs_next[PH_STEP] = max_upd(maxs_reg[PH_STEP], 32'(step_size));
                        for (int i = 0; i < HIST_BINS; i++)
                        begin
                            if (bin == 3'(i))
                                hist_next[i] = sat_inc(hist_reg[i]);
                        end
                        gap_next = max_upd(gap_reg, q_data.time_ms - sample_t_reg);
                    end
                    prev_x_next     = q_data.pos_x;
                    prev_y_next     = q_data.pos_y;
                    prev_valid_next = 1'b1;
                    sample_t_next   = q_data.time_ms;
                    moved_seen_next = 1'b0;
                    set_seen_next   = 1'b0;
                    steps_next      = sat_inc(session_reg ? steps_reg : '0);
                end
                CMD_MOTION:
                begin
                    if (session_reg)
                    begin
                        motion_next = sat_inc(motion_reg);
                        if (q_data.was_blocked)
                            skipped_next = sat_inc(skipped_reg);
                    end
                end
                CMD_MOVED:
                begin
                    if (session_reg && !moved_seen_reg)
                    begin
                        moved_seen_next = 1'b1;
                        moved_t_next    = q_data.time_ms;
                        sums_next[PH_WAKE] = sat_add(sums_reg[PH_WAKE],
                                                     q_data.time_ms - sample_t_reg);
                        maxs_next[PH_WAKE] = max_upd(maxs_reg[PH_WAKE],
                                                     q_data.time_ms - sample_t_reg);
                    end
                end
                CMD_SET:
                begin
                    if (session_reg && moved_seen_reg && !set_seen_reg)
                    begin
                        set_seen_next = 1'b1;
                        set_t_next    = q_data.time_ms;
                        sums_next[PH_APP] = sat_add(sums_reg[PH_APP],
                                                    q_data.time_ms - moved_t_reg);
                        maxs_next[PH_APP] = max_upd(maxs_reg[PH_APP],
                                                    q_data.time_ms - moved_t_reg);
                        sums_next[PH_COUNT] = sat_add(sums_reg[PH_COUNT],
                                                      32'(q_data.redraw_count));
                        maxs_next[PH_COUNT] = max_upd(maxs_reg[PH_COUNT],
                                                      32'(q_data.redraw_count));
                    end
                end
                CMD_UNBLOCK:
                begin
                    if (session_reg)
                    begin
                        for (int i = 0; i < REASON_SLOTS; i++)
                        begin
                            if (q_data.reason == 3'(i))
                                reasons_next[i] = sat_inc(reasons_reg[i]);
                        end
                        if (set_seen_reg)
                        begin
                            set_seen_next = 1'b0;
                            sums_next[PH_REDRAW] = sat_add(sums_reg[PH_REDRAW],
                                                           q_data.time_ms - set_t_reg);
                            maxs_next[PH_REDRAW] = max_upd(maxs_reg[PH_REDRAW],
                                                           q_data.time_ms - set_t_reg);
                        end
                    end
                end
                CMD_END:
                begin
                    if (session_reg)
                    begin
                        session_next = 1'b0;
                        elapsed_next = q_data.time_ms - start_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // readout sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            RD_IDLE:
            begin
                if (start_rd)
                    state_next = RD_BUSY;
            end
            RD_BUSY:
            begin
                if (load && idx_reg == LAST_IDX)
                    state_next = RD_IDLE;
            end
            default:
                state_next = RD_IDLE;
        endcase
    end

    // readout sequencer: outputs
    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        case (state_reg)
            RD_IDLE:
                pop = q_stat.not_empty;
            RD_BUSY:
                load = !out_valid_reg || stat.ready;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sel = '0;
        case (idx_reg)
            IDX_ELAPSED: sel = SW'(elapsed_reg);
            IDX_STEPS:   sel = SW'(steps_reg);
            IDX_GAP:     sel = SW'(gap_reg);
            IDX_MOTION:  sel = SW'(motion_reg);
            IDX_SKIPPED: sel = SW'(skipped_reg);
            default:     sel = '0;
        endcase
        for (int i = 0; i < PHASES; i++)
        begin
            if (idx_reg == 5'(IDX_PHASE + 2 * i))
                sel = SW'(sums_reg[i]);
            if (idx_reg == 5'(IDX_PHASE + 2 * i + 1))
                sel = SW'(maxs_reg[i]);
        end
        for (int i = 0; i < HIST_BINS; i++)
        begin
            if (idx_reg == 5'(IDX_HIST + i))
                sel = SW'(hist_reg[i]);
        end
        for (int i = 0; i < REASON_SLOTS; i++)
        begin
            if (idx_reg == 5'(STAT_FIXED + i))
                sel = SW'(reasons_reg[i]);
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (start_rd)
            idx_next = '0;
        else if (load)
            idx_next = idx_reg + 5'd1;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_index_next = idx_reg;
            out_value_next = (sel > OUT_MAX) ? 32'hFFFF_FFFF : sel[31:0];
            out_last_next  = (idx_reg == LAST_IDX);
        end
        else if (stat.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            start_reg      <= '0;
            sample_t_reg   <= '0;
            moved_t_reg    <= '0;
            moved_seen_reg <= 1'b0;
            set_t_reg      <= '0;
            set_seen_reg   <= 1'b0;
            steps_reg      <= '0;
            gap_reg        <= '0;
            motion_reg     <= '0;
            skipped_reg    <= '0;
            elapsed_reg    <= '0;
            for (int i = 0; i < PHASES; i++)
            begin
                sums_reg[i] <= '0;
                maxs_reg[i] <= '0;
            end
            for (int i = 0; i < HIST_BINS; i++)
                hist_reg[i] <= '0;
            for (int i = 0; i < REASON_SLOTS; i++)
                reasons_reg[i] <= '0;
            state_reg      <= RD_IDLE;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            session_reg    <= session_next;
            prev_valid_reg <= prev_valid_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            start_reg      <= start_next;
            sample_t_reg   <= sample_t_next;
            moved_t_reg    <= moved_t_next;
            moved_seen_reg <= moved_seen_next;
            set_t_reg      <= set_t_next;
            set_seen_reg   <= set_seen_next;
            steps_reg      <= steps_next;
            gap_reg        <= gap_next;
            motion_reg     <= motion_next;
            skipped_reg    <= skipped_next;
            elapsed_reg    <= elapsed_next;
            sums_reg       <= sums_next;
            maxs_reg       <= maxs_next;
            hist_reg       <= hist_next;
            reasons_reg    <= reasons_next;
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign stat.valid      = out_valid_reg;
    assign stat.stat_index = out_index_reg;
    assign stat.stat_value = out_value_reg;
    assign stat.last       = out_last_reg;

endmodule

// File: hdl/drag_latency_stat_monitor_core.sv
`timescale 1ns / 1ps
// Top level of the drag latency statistics monitor.
// Depends on dlsm_pkg, dlsm_if, dlsm_front, dlsm_fifo and dlsm_back.
//
// Usage:
//   evt  (sink):   timestamped event words; operation 0 sample, 1 motion,
//                  2 moved, 3 set, 4 unblock, 5 end; codes 6 and 7 are dropped.
//   stat (source): statistic words (stat_index, stat_value, last) sent only
//                  after an end event in an open session.
//   A sample with no session open opens one and clears all statistics but
//   the elapsed time. Throughput: one event word per cycle. Events pass a
//   two-entry queue; the back end pops them while no readout runs and updates
//   the statistics registers as it pops. An end event starts a readout of
//   22 + REASON_SLOTS words, one per cycle while stat.ready is high; the first
//   word is loaded into the output register once the sequencer is busy. During
//   the readout the back end takes nothing from the queue, so evt.ready drops
//   once the queue fills.
//   A stalled receiver holds the output register and pauses the readout.
//   Reset clears all statistics, closes the session and empties the queue.
module drag_latency_stat_monitor_core #(
    parameter int REASON_SLOTS = 5,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    dlsm_in_if.sink     evt,
    dlsm_out_if.source  stat
);
    import dlsm_pkg::*;

    logic    push;
    logic    pop;
    evt_t    push_data;
    evt_t    pop_data;
    q_stat_t q_stat;

    dlsm_front u_front (
        .evt       (evt),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    dlsm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    dlsm_back #(
        .REASON_SLOTS (REASON_SLOTS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (pop_data),
        .pop    (pop),
        .stat   (stat)
    );

endmodule

// File: tb/drag_latency_stat_monitor_checker.sv
`timescale 1ns / 1ps
// Checker for the drag latency statistics monitor: tracks the statistics from the
// accepted event words and compares every statistic word against the prediction.
// Depends on dlsm_pkg and dlsm_if.
module drag_latency_stat_monitor_checker #(
    parameter int REASON_SLOTS = 5
) (
    input  logic clk,
    input  logic rst_n,
    dlsm_in_if   evt,
    dlsm_out_if  stat,
    output int   mismatches,
    output int   outstanding,
    output int   words_checked,
    output int   readouts
);
    import dlsm_pkg::*;

    localparam int READOUT_LEN = STAT_FIXED + REASON_SLOTS;

    typedef struct packed {
        logic [4:0]  index;
        logic [31:0] value;
        logic        last;
    } stat_word_t;

    stat_word_t expected_stats[$];

    logic               session_on;
    logic               prev_known;
    logic signed [15:0] last_x;
    logic signed [15:0] last_y;
    logic [31:0]        t_start;
    logic [31:0]        t_prev_sample;
    logic [31:0]        t_moved;
    logic [31:0]        t_set;
    logic               moved_hit;
    logic               set_hit;
    logic [31:0]        steps;
    logic [31:0]        gap_max;
    logic [31:0]        motions;
    logic [31:0]        blocked_pkts;
    logic [31:0]        lat_sum [PHASES];
    logic [31:0]        lat_max [PHASES];
    logic [31:0]        size_hist [HIST_BINS];
    logic [31:0]        reasons [REASON_SLOTS];

    function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int size_bin(logic [31:0] d);
        if (d <= 32'd1)
            return 0;
        if (d == 32'd2)
            return 1;
        if (d <= 32'd4)
            return 2;
        if (d <= 32'd8)
            return 3;
        if (d <= 32'd16)
            return 4;
        if (d <= 32'd32)
            return 5;
        return 6;
    endfunction

    task automatic clear_stats();
        session_on    = 1'b0;
        prev_known    = 1'b0;
        last_x        = '0;
        last_y        = '0;
        t_start       = '0;
        t_prev_sample = '0;
        t_moved       = '0;
        t_set         = '0;
        moved_hit     = 1'b0;
        set_hit       = 1'b0;
        steps         = '0;
        gap_max       = '0;
        motions       = '0;
        blocked_pkts  = '0;
        for (int i = 0; i < PHASES; i++)
        begin
            lat_sum[i] = '0;
            lat_max[i] = '0;
        end
        for (int i = 0; i < HIST_BINS; i++)
            size_hist[i] = '0;
        for (int i = 0; i < REASON_SLOTS; i++)
            reasons[i] = '0;
    endtask

    task automatic log_phase(input int slot, input logic [31:0] v);
        lat_sum[slot] = add_clamped(lat_sum[slot], v);
        if (v > lat_max[slot])
            lat_max[slot] = v;
    endtask

    task automatic track_event(input logic [2:0] op, input logic [31:0] t,
                               input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic blk, input logic [15:0] rc, input logic [2:0] rsn);
        int          dx;
        int          dy;
        logic [31:0] step_len;
        logic [31:0] vals [READOUT_LEN];
        if (op == OP_SAMPLE)
        begin
            if (!session_on)
            begin
                clear_stats();
                session_on = 1'b1;
                t_start    = t;
            end
            if (prev_known)
            begin
                dx = int'(x) - int'(last_x);
                dy = int'(y) - int'(last_y);
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                step_len = (dx > dy) ? dx : dy;
                log_phase(PH_STEP, step_len);
                size_hist[size_bin(step_len)] = add_clamped(size_hist[size_bin(step_len)],
                                                            32'd1);
                if ((t - t_prev_sample) > gap_max)
                    gap_max = t - t_prev_sample;
            end
            last_x        = x;
            last_y        = y;
            prev_known    = 1'b1;
            t_prev_sample = t;
            moved_hit     = 1'b0;
            set_hit       = 1'b0;
            steps         = add_clamped(steps, 32'd1);
        end
        else if (session_on)
        begin
            case (op)
                OP_MOTION:
                begin
                    motions = add_clamped(motions, 32'd1);
                    if (blk)
                        blocked_pkts = add_clamped(blocked_pkts, 32'd1);
                end
                OP_MOVED:
                begin
                    if (!moved_hit)
                    begin
                        moved_hit = 1'b1;
                        t_moved   = t;
                        log_phase(PH_WAKE, t - t_prev_sample);
                    end
                end
                OP_SET:
                begin
                    if (moved_hit && !set_hit)
                    begin
                        set_hit = 1'b1;
                        t_set   = t;
                        log_phase(PH_APP, t - t_moved);
                        log_phase(PH_COUNT, {16'd0, rc});
                    end
                end
                OP_UNBLOCK:
                begin
                    if (rsn < REASON_SLOTS)
                        reasons[rsn] = add_clamped(reasons[rsn], 32'd1);
                    if (set_hit)
                    begin
                        log_phase(PH_REDRAW, t - t_set);
                        set_hit = 1'b0;
                    end
                end
                OP_END:
                begin
                    session_on            = 1'b0;
                    vals[IDX_ELAPSED]     = t - t_start;
                    vals[IDX_STEPS]       = steps;
                    vals[IDX_GAP]         = gap_max;
                    vals[IDX_MOTION]      = motions;
                    vals[IDX_SKIPPED]     = blocked_pkts;
                    for (int i = 0; i < PHASES; i++)
                    begin
                        vals[IDX_PHASE + 2 * i]     = lat_sum[i];
                        vals[IDX_PHASE + 2 * i + 1] = lat_max[i];
                    end
                    for (int i = 0; i < HIST_BINS; i++)
                        vals[IDX_HIST + i] = size_hist[i];
                    for (int i = 0; i < REASON_SLOTS; i++)
                        vals[STAT_FIXED + i] = reasons[i];
                    for (int k = 0; k < READOUT_LEN; k++)
                        expected_stats.push_back('{index: 5'(k), value: vals[k],
                                                   last: (k == READOUT_LEN - 1)});
                    readouts++;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stat_word_t want;
        if (!rst_n)
        begin
            clear_stats();
            expected_stats.delete();
            mismatches    = 0;
            outstanding   = 0;
            words_checked = 0;
            readouts      = 0;
        end
        else
        begin
            if (stat.valid && stat.ready)
            begin
                words_checked++;
                if (expected_stats.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected statistic word: stat_index %0d stat_value %0d",
                           stat.stat_index, stat.stat_value);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (stat.stat_index !== want.index)
                    begin
                        mismatches++;
                        $error("stat_index: expected %0d, got %0d", want.index, stat.stat_index);
                    end
                    if (stat.stat_value !== want.value)
                    begin
                        mismatches++;
                        $error("stat_value (index %0d): expected %0d, got %0d",
                               want.index, want.value, stat.stat_value);
                    end
                    if (stat.last !== want.last)
                    begin
                        mismatches++;
                        $error("last (index %0d): expected %0d, got %0d",
                               want.index, want.last, stat.last);
                    end
                end
            end
            if (evt.valid && evt.ready)
                track_event(evt.operation, evt.time_ms, evt.pos_x, evt.pos_y,
                            evt.was_blocked, evt.redraw_count, evt.reason);
            outstanding = expected_stats.size();
        end
    end

endmodule

// File: tb/drag_latency_stat_monitor_core_tb.sv
`timescale 1ns / 1ps
// Top of the drag latency statistics monitor bench: clock, reset, event and drain
// traffic with random idling, and the final verdict.
// Depends on dlsm_pkg, dlsm_if, drag_latency_stat_monitor_core and the checker.
module drag_latency_stat_monitor_core_tb;
    import dlsm_pkg::*;

    localparam int         REASON_SLOTS  = 5;
    localparam int         COUNT_WIDTH   = 32;
    localparam logic [2:0] OP_SPARE_LO   = 3'd6;
    localparam logic [2:0] OP_SPARE_HI   = 3'd7;
    localparam int         DIRECTED_WORDS = 25;
    localparam int         RANDOM_WORDS  = 360;
    localparam int         DRAIN_CYCLES  = 16;
    localparam int         CYCLE_LIMIT   = 400000;

    logic        clk;
    logic        rst_n;
    int          cycle_count = 0;
    int          words_sent = 0;
    int          sessions = 0;
    int          mismatches;
    int          outstanding;
    int          words_checked;
    int          readouts;
    bit          evt_calm = 1'b0;
    bit          stat_calm = 1'b0;
    logic [31:0] now_ms;
    logic [15:0] cur_x;
    logic [15:0] cur_y;

    dlsm_in_if  evt_ch();
    dlsm_out_if stat_ch();

    drag_latency_stat_monitor_core #(
        .REASON_SLOTS (REASON_SLOTS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .stat  (stat_ch)
    );

    drag_latency_stat_monitor_checker #(
        .REASON_SLOTS (REASON_SLOTS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt_ch),
        .stat          (stat_ch),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .readouts      (readouts)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d statistic words still due",
                   cycle_count, outstanding);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] step_ms();
        if ($urandom_range(0, 15) == 0)
            return $urandom();
        return $urandom_range(0, 40);
    endfunction

    function automatic logic [15:0] jitter();
        logic [15:0] mag;
        case ($urandom_range(0, 9))
            0: mag = 16'd0;
            1: mag = 16'd1;
            2: mag = 16'd2;
            3: mag = 16'($urandom_range(3, 4));
            4: mag = 16'($urandom_range(5, 8));
            5: mag = 16'($urandom_range(9, 16));
            6: mag = 16'($urandom_range(17, 32));
            7: mag = 16'($urandom_range(33, 300));
            8: mag = 16'($urandom());
            default: mag = 16'($urandom_range(0, 3));
        endcase
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    task automatic send_evt(input logic [2:0] op, input logic [31:0] t, input logic [15:0] x,
                            input logic [15:0] y, input logic blk, input logic [15:0] rc,
                            input logic [2:0] rsn);
        int gap;
        gap = evt_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid        <= 1'b1;
        evt_ch.operation    <= op;
        evt_ch.time_ms      <= t;
        evt_ch.pos_x        <= x;
        evt_ch.pos_y        <= y;
        evt_ch.was_blocked  <= blk;
        evt_ch.redraw_count <= rc;
        evt_ch.reason       <= rsn;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        words_sent++;
    endtask

    task automatic send_op(input logic [2:0] op);
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] rc;
        logic [2:0]  rsn;
        now_ms += step_ms();
        if (op == OP_SAMPLE)
        begin
            cur_x += jitter();
            cur_y += jitter();
            x = cur_x;
            y = cur_y;
        end
        else
        begin
            x = 16'($urandom());
            y = 16'($urandom());
        end
        rc  = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
        rsn = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_evt(op, now_ms, x, y, 1'($urandom()), rc, rsn);
    endtask

    // one pointer step; most follow moved, set, unblock in order
    task automatic drag_step();
        int shape;
        shape = $urandom_range(0, 11);
        repeat ($urandom_range(0, 3)) send_op(OP_MOTION);
        if (shape == 8)
            send_op(OP_END);
        if (shape != 0)
            send_op(OP_MOVED);
        if (shape == 1)
            send_op(OP_MOVED);
        if (shape != 2)
            send_op(OP_SET);
        if (shape == 3)
            send_op(OP_SET);
        if (shape != 4)
            send_op(OP_UNBLOCK);
        if (shape == 5)
        begin
            send_op(OP_SET);
            send_op(OP_UNBLOCK);
        end
        if (shape == 6)
            send_op(($urandom_range(0, 1) == 1) ? OP_SPARE_LO : OP_SPARE_HI);
        if (shape == 7)
            send_op(OP_MOTION);
        send_op(OP_SAMPLE);
    endtask

    task automatic drag_session();
        evt_calm  = ($urandom_range(0, 3) == 0);
        stat_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
            send_op(3'($urandom_range(1, 7)));
        send_op(OP_SAMPLE);
        repeat ($urandom_range(0, 6)) drag_step();
        send_op(OP_END);
        sessions++;
    endtask

    initial
    begin
        int stall;
        stat_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = stat_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                stat_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            stat_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!stat_ch.valid);
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        evt_ch.valid        <= 1'b0;
        evt_ch.operation    <= OP_SAMPLE;
        evt_ch.time_ms      <= '0;
        evt_ch.pos_x        <= '0;
        evt_ch.pos_y        <= '0;
        evt_ch.was_blocked  <= 1'b0;
        evt_ch.redraw_count <= '0;
        evt_ch.reason       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle session: everything but a sample is dropped
        send_evt(OP_END,      32'd100, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_MOTION,   32'd110, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 3'd7);
        send_evt(OP_MOVED,    32'd120, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_SET,      32'd130, 16'h0000, 16'h0000, 1'b0, 16'd5,    3'd0);
        send_evt(OP_UNBLOCK,  32'd140, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd2);
        send_evt(OP_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 3'd7);
        // open near the top of the time range, corner position
        send_evt(OP_SAMPLE,   32'hFFFF_FFF0, 16'h8000, 16'h7FFF, 1'b1, 16'hFFFF, 3'd7);
        send_evt(OP_SET,      32'hFFFF_FFF2, 16'h0000, 16'h0000, 1'b0, 16'd9,    3'd0);
        send_evt(OP_UNBLOCK,  32'hFFFF_FFF3, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd7);
        send_evt(OP_UNBLOCK,  32'hFFFF_FFF4, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd4);
        send_evt(OP_MOVED,    32'hFFFF_FFEF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_MOVED,    32'hFFFF_FFF8, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_SET,      32'h0000_0002, 16'h0000, 16'h0000, 1'b0, 16'hFFFF, 3'd0);
        send_evt(OP_SET,      32'd5,   16'h0000, 16'h0000, 1'b0, 16'd1,    3'd0);
        send_evt(OP_UNBLOCK,  32'd9,   16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_UNBLOCK,  32'd10,  16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd1);
        send_evt(OP_MOTION,   32'd11,  16'h0000, 16'h0000, 1'b1, 16'h0000, 3'd0);
        send_evt(OP_MOTION,   32'd12,  16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 3'd7);
        send_evt(OP_SPARE_HI, 32'd13,  16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 3'd7);
        // full-scale step, then a wake latency that saturates the sum
        send_evt(OP_SAMPLE,   32'h0000_0010, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_MOVED,    32'h0000_000F, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_SAMPLE,   32'h0000_0020, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_UNBLOCK,  32'h0000_0021, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd3);
        send_evt(OP_END,      32'h0000_0030, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);
        send_evt(OP_END,      32'h0000_0040, 16'h0000, 16'h0000, 1'b0, 16'h0000, 3'd0);

        now_ms = 32'h0000_0040;
        cur_x  = '0;
        cur_y  = '0;
        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS)
            drag_session();

        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d event words (%0d random sessions after the directed part).",
                 words_sent, sessions);
        $display("Checked %0d statistic words from %0d readouts, %0d mismatches.",
                 words_checked, readouts, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
